// ===== hw/rtl/pooled_linked_list_manager_assert.svh =====
// assertion macros shared by the checker of the pooled linked list manager
// depends on nothing; included by the checker file
`ifndef POOLED_LINKED_LIST_MANAGER_ASSERT_SVH
`define POOLED_LINKED_LIST_MANAGER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PLLM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pllm check failed in same cycle");

// consequent checked in the cycle after the antecedent
`define PLLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pllm check failed one cycle later");

`endif

// ===== hw/rtl/pllm_pkg.sv =====
// shared types and constants of the pooled linked list manager
// no dependencies
`timescale 1ns / 1ps

package pllm_pkg;

	localparam int FUNC_W  = 2;
	localparam int LSLOT_W = 6;
	localparam int SCODE_W = 32;
	localparam int SLOT_W  = 10;

	// operation codes; only the high bit separates insert from remove
	localparam logic [FUNC_W-1:0] FN_INS_HEAD = 2'd0;
	localparam logic [FUNC_W-1:0] FN_INS_TAIL = 2'd1;
	localparam logic [FUNC_W-1:0] FN_REMOVE   = 2'd2;
	localparam int FN_SEL_BIT = 1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_UNKNOWN   = 2'd2,
		ST_POOL_FULL = 2'd3
	} status_t;

endpackage

// ===== hw/rtl/pooled_linked_list_manager.sv =====
// channel  | handshake            | payload
// req      | req_valid, req_stall | func, list_slot, song_code, song_known
// rsp      | rsp_valid, rsp_stall | status, node_slot
//
// insert: S_RD then S_DONE, with S_LINK between them when a tail insert links behind an old tail
// remove: S_RD, one S_WALK step per node walked, S_UNLINK when the node had a predecessor, then S_DONE;
//   the walk is bound by the single read port of the node memories
// after reset a clearing pass over all LIST_COUNT entries empties the list table, req stalled
// one transaction at a time; a finished result waits in the output register under rsp_stall
// depends on pllm_pkg and pllm_ram
`timescale 1ns / 1ps

module pooled_linked_list_manager #(
	parameter int POOL_DEPTH = 1024,
	parameter int LIST_COUNT = 64,
	parameter int CODE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [pllm_pkg::FUNC_W-1:0]    func,
	input  logic [pllm_pkg::LSLOT_W-1:0]   list_slot,
	input  logic [pllm_pkg::SCODE_W-1:0]   song_code,
	input  logic                           song_known,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output pllm_pkg::status_t              status,
	output logic [pllm_pkg::SLOT_W-1:0]    node_slot
);

	import pllm_pkg::*;

	localparam int IDX_W = $clog2(POOL_DEPTH);
	localparam int PTR_W = $clog2(POOL_DEPTH + 1);
	localparam int LS_W  = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
	localparam int LE_W  = 2 * PTR_W;
	localparam logic [PTR_W-1:0] NULL_P    = PTR_W'(POOL_DEPTH);
	localparam logic [LS_W-1:0]  LS_LAST   = LS_W'(LIST_COUNT - 1);
	localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(POOL_DEPTH - 1);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_RD     = 7'b0000100,
		S_LINK   = 7'b0001000,
		S_WALK   = 7'b0010000,
		S_UNLINK = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	function automatic logic is_node(input logic [PTR_W-1:0] p);
		return p < NULL_P;
	endfunction

	state_t            state_q;
	logic [LS_W-1:0]   clr_q;
	logic [FUNC_W-1:0] func_q;
	logic [LS_W-1:0]   ls_q;
	logic [CODE_WIDTH-1:0] code_q;
	logic              known_q;
	logic [PTR_W-1:0]  hd_q, tl_q, cur_q, prev_q, nxt_q;
	logic [IDX_W-1:0]  steps_q;
	logic [PTR_W-1:0]  free_head_q, bump_q;
	status_t           r_status_q;
	logic [PTR_W-1:0]  r_slot_q;
	logic              rsp_valid_q;
	status_t           status_q;
	logic [SLOT_W-1:0] node_slot_q;

	// memory ports
	logic                  nc_we, nc_re;
	logic [IDX_W-1:0]      nc_waddr, nc_raddr;
	logic [CODE_WIDTH-1:0] nc_wdata, nc_rdata;
	logic                  nn_we, nn_re;
	logic [IDX_W-1:0]      nn_waddr, nn_raddr;
	logic [PTR_W-1:0]      nn_wdata, nn_rdata;
	logic                  lm_we, lm_re;
	logic [LS_W-1:0]       lm_waddr, lm_raddr;
	logic [LE_W-1:0]       lm_wdata, lm_rdata;

	logic [LS_W-1:0]  ls_map;
	logic             req_fire, out_free, is_remove, ins_tail;
	logic [PTR_W-1:0] lm_hd, lm_tl;
	logic             fl_avail, bump_avail, ins_ok, tail_link;
	logic [PTR_W-1:0] new_p;
	logic             match, give_up;
	logic [PTR_W-1:0] wnext_n, new_head, new_tail;

	pllm_ram #(.DEPTH(POOL_DEPTH), .WIDTH(CODE_WIDTH)) u_code (
		.clk, .we(nc_we), .waddr(nc_waddr), .wdata(nc_wdata),
		.re(nc_re), .raddr(nc_raddr), .rdata(nc_rdata)
	);

	pllm_ram #(.DEPTH(POOL_DEPTH), .WIDTH(PTR_W)) u_next (
		.clk, .we(nn_we), .waddr(nn_waddr), .wdata(nn_wdata),
		.re(nn_re), .raddr(nn_raddr), .rdata(nn_rdata)
	);

	pllm_ram #(.DEPTH(LIST_COUNT), .WIDTH(LE_W)) u_list (
		.clk, .we(lm_we), .waddr(lm_waddr), .wdata(lm_wdata),
		.re(lm_re), .raddr(lm_raddr), .rdata(lm_rdata)
	);

	// list index folded into range
	always_comb begin
		ls_map = '0;
		for (int i = 0; i < (1 << LSLOT_W); i++) begin
			if (list_slot == LSLOT_W'(i)) begin
				ls_map = LS_W'(i % LIST_COUNT);
			end
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign is_remove = func_q[FN_SEL_BIT];
	assign ins_tail  = (func_q == FN_INS_TAIL);

	assign lm_hd = lm_rdata[LE_W-1:PTR_W];
	assign lm_tl = lm_rdata[PTR_W-1:0];

	assign fl_avail   = is_node(free_head_q);
	assign bump_avail = (bump_q < NULL_P);
	assign new_p      = fl_avail ? free_head_q : bump_q;
	assign ins_ok     = known_q && (fl_avail || bump_avail);
	assign tail_link  = ins_tail && is_node(lm_hd) && is_node(lm_tl);

	assign match   = (nc_rdata == code_q);
	assign wnext_n = is_node(nn_rdata) ? nn_rdata : NULL_P;
	assign give_up = !match && (!is_node(nn_rdata) || steps_q == STEP_LAST);

	always_comb begin
		new_head = is_node(prev_q) ? hd_q : wnext_n;
		new_tail = (cur_q == tl_q) ? prev_q : tl_q;
		if (!is_node(new_head)) begin
			new_tail = NULL_P;
		end
	end

	always_comb begin
		nc_we    = 1'b0;
		nc_waddr = new_p[IDX_W-1:0];
		nc_wdata = code_q;
		nc_re    = 1'b0;
		nc_raddr = lm_hd[IDX_W-1:0];
		nn_we    = 1'b0;
		nn_waddr = new_p[IDX_W-1:0];
		nn_wdata = NULL_P;
		nn_re    = 1'b0;
		nn_raddr = lm_hd[IDX_W-1:0];
		lm_we    = 1'b0;
		lm_waddr = ls_q;
		lm_wdata = {NULL_P, NULL_P};
		lm_re    = 1'b0;
		lm_raddr = ls_map;
		unique case (state_q)
			S_CLEAR: begin
				lm_we    = 1'b1;
				lm_waddr = clr_q;
			end
			S_IDLE: begin
				// fetch list entry and the successor of the free list head together
				lm_re    = req_fire;
				nn_re    = req_fire;
				nn_raddr = free_head_q[IDX_W-1:0];
			end
			S_RD: begin
				if (!is_remove) begin
					if (ins_ok) begin
						nc_we = 1'b1;
						nn_we = 1'b1;
						lm_we = 1'b1;
						if (ins_tail) begin
							nn_wdata = NULL_P;
							lm_wdata = tail_link ? {lm_hd, new_p} : {new_p, new_p};
						end else begin
							nn_wdata = is_node(lm_hd) ? lm_hd : NULL_P;
							lm_wdata = {new_p, (is_node(lm_tl) ? lm_tl : new_p)};
						end
					end
				end else if (is_node(lm_hd)) begin
					nc_re = 1'b1;
					nn_re = 1'b1;
				end
			end
			S_LINK: begin
				nn_we    = 1'b1;
				nn_waddr = tl_q[IDX_W-1:0];
				nn_wdata = cur_q;
			end
			S_WALK: begin
				if (match) begin
					// freed node goes on top of the free list
					nn_we    = 1'b1;
					nn_waddr = cur_q[IDX_W-1:0];
					nn_wdata = free_head_q;
					lm_we    = 1'b1;
					lm_wdata = {new_head, new_tail};
				end else if (!give_up) begin
					nc_re    = 1'b1;
					nn_re    = 1'b1;
					nc_raddr = nn_rdata[IDX_W-1:0];
					nn_raddr = nn_rdata[IDX_W-1:0];
				end
			end
			S_UNLINK: begin
				nn_we    = 1'b1;
				nn_waddr = prev_q[IDX_W-1:0];
				nn_wdata = nxt_q;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			free_head_q <= NULL_P;
			bump_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + LS_W'(1);
					if (clr_q == LS_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (!is_remove) begin
						state_q <= S_DONE;
						if (ins_ok) begin
							if (fl_avail) begin
								free_head_q <= is_node(nn_rdata) ? nn_rdata : NULL_P;
							end else begin
								bump_q <= bump_q + PTR_W'(1);
							end
							if (tail_link) begin
								state_q <= S_LINK;
							end
						end
					end else begin
						state_q <= is_node(lm_hd) ? S_WALK : S_DONE;
					end
				end
				S_LINK: begin
					state_q <= S_DONE;
				end
				S_WALK: begin
					if (match) begin
						free_head_q <= cur_q;
						state_q     <= is_node(prev_q) ? S_UNLINK : S_DONE;
					end else if (give_up) begin
						state_q <= S_DONE;
					end
				end
				S_UNLINK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_fire) begin
			func_q  <= func;
			ls_q    <= ls_map;
			code_q  <= CODE_WIDTH'(song_code);
			known_q <= song_known;
		end
		if (state_q == S_RD) begin
			hd_q    <= lm_hd;
			tl_q    <= lm_tl;
			cur_q   <= is_remove ? lm_hd : new_p;
			prev_q  <= NULL_P;
			steps_q <= '0;
			r_slot_q <= '0;
			if (!is_remove) begin
				if (!known_q) begin
					r_status_q <= ST_UNKNOWN;
				end else if (!ins_ok) begin
					r_status_q <= ST_POOL_FULL;
				end else begin
					r_status_q <= ST_OK;
					r_slot_q   <= new_p;
				end
			end else begin
				r_status_q <= ST_NOT_FOUND;
			end
		end
		if (state_q == S_WALK) begin
			if (match) begin
				r_status_q <= ST_OK;
				r_slot_q   <= cur_q;
				nxt_q      <= wnext_n;
			end else if (!give_up) begin
				prev_q  <= cur_q;
				cur_q   <= nn_rdata;
				steps_q <= steps_q + IDX_W'(1);
			end
		end
		if (state_q == S_DONE && out_free) begin
			status_q    <= r_status_q;
			node_slot_q <= SLOT_W'(r_slot_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign node_slot = node_slot_q;

endmodule

// ===== hw/rtl/pllm_ram.sv =====
// simple dual port synchronous memory, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module pllm_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/pllm_checker.sv =====
// port level checks of the pooled linked list manager, bound to the top level
// depends on pllm_pkg and pooled_linked_list_manager_assert.svh
`timescale 1ns / 1ps
`include "pooled_linked_list_manager_assert.svh"

module pllm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_stall,
	input logic [pllm_pkg::FUNC_W-1:0]  func,
	input logic [pllm_pkg::LSLOT_W-1:0] list_slot,
	input logic [pllm_pkg::SCODE_W-1:0] song_code,
	input logic                         song_known,
	input logic                         rsp_valid,
	input logic                         rsp_stall,
	input pllm_pkg::status_t            status,
	input logic [pllm_pkg::SLOT_W-1:0]  node_slot
);

	import pllm_pkg::*;

	// a stalled result stays on the port
	`PLLM_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid)

	// failed operations report slot zero
	`PLLM_ASSERT_SAME(a_fail_slot, clk, arst_n, rsp_valid && status != ST_OK, node_slot == '0)

	// one transaction in flight: accepting one closes the request side at once
	`PLLM_ASSERT_NEXT(a_one_inflight, clk, arst_n, req_valid && !req_stall, req_stall)

	// no result appears in the cycle right after an accept
	`PLLM_ASSERT_NEXT(a_no_early_rsp, clk, arst_n, req_valid && !req_stall && !rsp_valid,
		!rsp_valid)

endmodule

bind pooled_linked_list_manager pllm_checker u_pllm_checker (.*);

// ===== sim/tb_pooled_linked_list_manager.sv =====
// self-checking testbench for pooled_linked_list_manager: directed table, then random phases
// depends on pllm_pkg and the pooled_linked_list_manager rtl
`timescale 1ns / 1ps

module tb_pooled_linked_list_manager;
	import pllm_pkg::*;

	localparam int POOL_N = 1024;
	localparam int LIST_N = 64;
	localparam logic [10:0] NIL = 11'd1024;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		status_t     st;
		logic [9:0]  slot;
	} rsp_rec_t;

	typedef struct packed {
		logic [1:0]  fn;
		logic [5:0]  ls;
		logic [31:0] code;
		logic        kn;
		logic        typed;
		status_t     st;
		logic [9:0]  slot;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  func = FN_INS_HEAD;
	logic [5:0]  list_slot = '0;
	logic [31:0] song_code = '0;
	logic        song_known = 1'b0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	status_t     status;
	logic [9:0]  node_slot;

	// shadow copy of the node pool and list table
	logic [31:0] pool_code [POOL_N];
	logic [10:0] pool_link [POOL_N];
	logic [10:0] head_ptr [LIST_N];
	logic [10:0] tail_ptr [LIST_N];
	logic [10:0] bump_next;
	logic [10:0] free_top;

	rsp_rec_t pending_rsp [$];
	dir_row_t dir_rows [$];
	int mismatches = 0;
	int full_seen = 0;
	int sent_cnt = 0;
	bit quiet = 1'b0;

	pooled_linked_list_manager u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.func       (func),
		.list_slot  (list_slot),
		.song_code  (song_code),
		.song_known (song_known),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.node_slot  (node_slot)
	);

	always #5 clk = ~clk;

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// free list first, then the bump counter
	function automatic logic [10:0] grab_node();
		logic [10:0] p;
		if (free_top < NIL) begin
			p = free_top;
			free_top = (pool_link[p[9:0]] < NIL) ? pool_link[p[9:0]] : NIL;
		end else if (bump_next < NIL) begin
			p = bump_next;
			bump_next = bump_next + 11'd1;
		end else begin
			p = NIL;
		end
		return p;
	endfunction

	task automatic predict_op(input logic [1:0] fn, input logic [5:0] ls,
			input logic [31:0] code, input logic kn, output rsp_rec_t res);
		logic [10:0] p, cur, prv, nxt;
		int steps;
		bit found;
		res.st = ST_OK;
		res.slot = '0;
		if (!fn[FN_SEL_BIT]) begin
			if (!kn) begin
				res.st = ST_UNKNOWN;
			end else begin
				p = grab_node();
				if (p >= NIL) begin
					res.st = ST_POOL_FULL;
				end else begin
					pool_code[p[9:0]] = code;
					if (fn == FN_INS_HEAD) begin
						pool_link[p[9:0]] = (head_ptr[ls] < NIL) ? head_ptr[ls] : NIL;
						head_ptr[ls] = p;
						if (tail_ptr[ls] >= NIL)
							tail_ptr[ls] = p;
					end else begin
						pool_link[p[9:0]] = NIL;
						if (head_ptr[ls] >= NIL || tail_ptr[ls] >= NIL) begin
							head_ptr[ls] = p;
							tail_ptr[ls] = p;
						end else begin
							pool_link[tail_ptr[ls][9:0]] = p;
							tail_ptr[ls] = p;
						end
					end
					res.slot = p[9:0];
				end
			end
		end else begin
			cur = head_ptr[ls];
			prv = NIL;
			steps = 0;
			found = 1'b0;
			while (!found && cur < NIL && steps < POOL_N) begin
				if (pool_code[cur[9:0]] == code) begin
					found = 1'b1;
				end else begin
					prv = cur;
					cur = pool_link[cur[9:0]];
					steps++;
				end
			end
			if (!found) begin
				res.st = ST_NOT_FOUND;
			end else begin
				nxt = (pool_link[cur[9:0]] < NIL) ? pool_link[cur[9:0]] : NIL;
				if (prv >= NIL)
					head_ptr[ls] = nxt;
				else
					pool_link[prv[9:0]] = nxt;
				if (cur == tail_ptr[ls])
					tail_ptr[ls] = prv;
				if (head_ptr[ls] >= NIL)
					tail_ptr[ls] = NIL;
				pool_link[cur[9:0]] = free_top;
				free_top = cur;
				res.slot = cur[9:0];
			end
		end
	endtask

	function automatic void add_row(logic [1:0] fn, logic [5:0] ls, logic [31:0] code,
			logic kn, logic typed, status_t st, logic [9:0] slot);
		dir_row_t r;
		r.fn = fn;
		r.ls = ls;
		r.code = code;
		r.kn = kn;
		r.typed = typed;
		r.st = st;
		r.slot = slot;
		dir_rows.push_back(r);
	endfunction

	// one request transaction; valid stays high into the next one when there is no gap
	task automatic send_txn(input logic [1:0] fn, input logic [5:0] ls, input logic [31:0] code,
			input logic kn, input logic typed, input rsp_rec_t typed_rsp);
		int gap;
		rsp_rec_t res;
		gap = quiet ? 0 : gap_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		func <= fn;
		list_slot <= ls;
		song_code <= code;
		song_known <= kn;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predict_op(fn, ls, code, kn, res);
		if (res.st == ST_POOL_FULL)
			full_seen++;
		pending_rsp.push_back(typed ? typed_rsp : res);
		sent_cnt++;
		if (sent_cnt % 50 == 0)
			quiet = ($urandom_range(0, 4) == 0);
	endtask

	// small code alphabet so removes find their target, full range now and then
	task automatic rand_item(input int ins_pct, input int ls_max, output logic [1:0] fn,
			output logic [5:0] ls, output logic [31:0] code, output logic kn);
		if ($urandom_range(0, 99) < ins_pct)
			fn = 2'($urandom_range(0, 1));
		else
			fn = 2'($urandom_range(2, 3));
		if ($urandom_range(0, 99) < 85)
			ls = 6'($urandom_range(0, ls_max));
		else
			ls = 6'($urandom_range(0, 63));
		if ($urandom_range(0, 99) < 75)
			code = 32'($urandom_range(0, 15));
		else
			code = $urandom;
		kn = ($urandom_range(0, 99) < 90);
	endtask

	// response side: check every accepted transaction, stall at random
	initial begin
		rsp_rec_t want;
		int stall_cnt;
		stall_cnt = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected response: status %0d node_slot %0d",
							status, node_slot);
					mismatches++;
				end else begin
					want = pending_rsp.pop_front();
					if (status !== want.st || node_slot !== want.slot) begin
						if (mismatches < 10)
							$display("response wrong: status exp %0d got %0d, node_slot exp %0d got %0d",
								want.st, status, want.slot, node_slot);
						mismatches++;
					end
				end
			end
			if (stall_cnt == 0)
				stall_cnt = quiet ? 0 : gap_len();
			if (stall_cnt > 0) begin
				rsp_stall <= 1'b1;
				stall_cnt--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// ends the run if no transaction moves on either side for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("pooled_linked_list_manager: mismatch");
		$finish;
	end

	initial begin
		int n;
		logic [1:0] fn;
		logic [5:0] ls;
		logic [31:0] code;
		logic kn;
		rsp_rec_t typed_rsp;
		rsp_rec_t no_rsp;

		no_rsp.st = ST_OK;
		no_rsp.slot = '0;
		for (n = 0; n < POOL_N; n++) begin
			pool_code[n] = '0;
			pool_link[n] = '0;
		end
		for (n = 0; n < LIST_N; n++) begin
			head_ptr[n] = NIL;
			tail_ptr[n] = NIL;
		end
		bump_next = '0;
		free_top = NIL;

		add_row(FN_REMOVE,   6'd0,  32'h0,        1'b1, 1'b1, ST_NOT_FOUND, 10'd0);
		add_row(FN_INS_HEAD, 6'd0,  32'h0,        1'b0, 1'b1, ST_UNKNOWN,   10'd0);
		add_row(FN_INS_TAIL, 6'd63, 32'hFFFFFFFF, 1'b0, 1'b1, ST_UNKNOWN,   10'd0);
		add_row(FN_INS_HEAD, 6'd0,  32'h0,        1'b1, 1'b1, ST_OK,        10'd0);
		add_row(FN_INS_TAIL, 6'd0,  32'hFFFFFFFF, 1'b1, 1'b1, ST_OK,        10'd1);
		add_row(FN_INS_HEAD, 6'd63, 32'hA5A5A5A5, 1'b1, 1'b1, ST_OK,        10'd2);
		add_row(FN_INS_TAIL, 6'd63, 32'h5A5A5A5A, 1'b1, 1'b1, ST_OK,        10'd3);
		add_row(FN_INS_TAIL, 6'd0,  32'h0,        1'b1, 1'b1, ST_OK,        10'd4);
		// remove does not look at the catalogue bit
		add_row(FN_REMOVE,   6'd0,  32'h0,        1'b0, 1'b1, ST_OK,        10'd0);
		// selector three decodes as remove
		add_row(2'd3,        6'd0,  32'h0,        1'b1, 1'b0, ST_OK,        10'd0);
		add_row(FN_INS_HEAD, 6'd5,  32'd123,      1'b1, 1'b0, ST_OK,        10'd0);
		add_row(FN_REMOVE,   6'd0,  32'h0,        1'b1, 1'b1, ST_NOT_FOUND, 10'd0);
		add_row(FN_REMOVE,   6'd63, 32'h5A5A5A5A, 1'b1, 1'b0, ST_OK,        10'd0);
		add_row(FN_REMOVE,   6'd63, 32'hA5A5A5A5, 1'b1, 1'b0, ST_OK,        10'd0);
		add_row(FN_INS_TAIL, 6'd63, 32'd7,        1'b1, 1'b0, ST_OK,        10'd0);
		add_row(FN_INS_HEAD, 6'd63, 32'd8,        1'b1, 1'b0, ST_OK,        10'd0);
		add_row(FN_REMOVE,   6'd1,  32'hFFFFFFFF, 1'b1, 1'b1, ST_NOT_FOUND, 10'd0);
		add_row(FN_REMOVE,   6'd0,  32'hFFFFFFFF, 1'b1, 1'b0, ST_OK,        10'd0);
		add_row(FN_INS_TAIL, 6'd0,  32'd9,        1'b1, 1'b0, ST_OK,        10'd0);
		add_row(2'd3,        6'd62, 32'd1,        1'b1, 1'b1, ST_NOT_FOUND, 10'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[n]) begin
			typed_rsp.st = dir_rows[n].st;
			typed_rsp.slot = dir_rows[n].slot;
			send_txn(dir_rows[n].fn, dir_rows[n].ls, dir_rows[n].code, dir_rows[n].kn,
				dir_rows[n].typed, typed_rsp);
		end

		// mixed traffic on a few lists
		for (n = 0; n < 30; n++) begin
			rand_item(60, 7, fn, ls, code, kn);
			send_txn(fn, ls, code, kn, 1'b0, no_rsp);
		end

		// hold the sender until every response is back
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);

		// fill the pool on a few long lists until it reports full several times
		n = 0;
		while (full_seen < 5 && n < 1500) begin
			rand_item(100, 3, fn, ls, code, kn);
			kn = 1'b1;
			send_txn(fn, ls, code, kn, 1'b0, no_rsp);
			n++;
		end

		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);

		// removal heavy: long walks, freed nodes reused by inserts
		for (n = 0; n < 40; n++) begin
			rand_item(35, 3, fn, ls, code, kn);
			send_txn(fn, ls, code, kn, 1'b0, no_rsp);
		end

		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("pooled_linked_list_manager: match");
		else
			$display("pooled_linked_list_manager: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pllm_pkg.sv
hw/rtl/pllm_ram.sv
hw/rtl/pooled_linked_list_manager.sv
hw/rtl/pllm_checker.sv
sim/tb_pooled_linked_list_manager.sv
